// File: rtl/core/mwgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mwgb_pkg;

	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 64;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ROW_LIM   = 2'd0;
	localparam cfg_idx_t REG_STATE_LIM = 2'd1;

	localparam logic [3:0] ROW_LIM_RST   = 4'd8;
	localparam logic [7:0] STATE_LIM_RST = 8'd255;

	typedef struct packed {
		logic [63:0] row_bits;
		logic        last_row;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  basis_mask;
		logic [63:0] basis_row;
		logic [6:0]  weight;
		logic [9:0]  weight_sum;
		logic        last;
		logic        empty_res;
		logic        error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD,
		ST_GV,
		ST_CHK,
		ST_RED,
		ST_XOR,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// File: rtl/core/mwgb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mwgb_in_if;
	logic               valid;
	logic               ready;
	mwgb_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mwgb_out_if;
	logic                valid;
	logic                ready;
	mwgb_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mwgb_cfg_if;
	logic               valid;
	logic               ready;
	mwgb_pkg::cfg_idx_t index;
	logic [7:0]         data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/min_weight_gf2_basis.sv
`timescale 1ns / 1ps
`default_nettype none
// Minimum-weight GF(2) basis of a window of up to ROWS row vectors. Rows are
// taken one per cycle into a small row memory until a request with last_row
// set closes the window. The block then walks every nonzero row combination
// in Gray-code order, one weight class per pass (weight zero first, then each
// weight that exists, lowest first; each pass also finds the next weight, so
// empty classes are skipped), and offers each combination of the current
// weight to a pivot basis held in a COLS-entry memory keyed by the highest
// set bit. A combination of another weight takes a row-memory read, an XOR
// update and a weight check; an offered one then also goes through reduction,
// with one pivot memory read and XOR per pivot met. Input is stalled during
// that sweep. Each accepted vector is one result request; the last one
// carries last. A window of rank zero yields one empty_res request, and a
// window over ROWS or the row limit or state limit registers yields one
// error request. Results pass through an output register so the sweep keeps
// going while one waits, but halts on a further accepted vector until the
// output is free. Configuration writes are accepted every cycle.
module min_weight_gf2_basis #(
	parameter int ROWS = mwgb_pkg::ROWS_DEF,
	parameter int COLS = mwgb_pkg::COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mwgb_cfg_if.sink   cfg,
	mwgb_in_if.sink    src,
	mwgb_out_if.source res
);
	import mwgb_pkg::*;

	localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;

	// popcount of a vector
	function automatic logic [6:0] pop_cnt(input logic [COLS-1:0] x);
		logic [6:0] n;
		n = '0;
		for (int b = 0; b < COLS; b++) n = n + 7'(x[b]);
		return n;
	endfunction

	// index of the lowest set bit, selects the row that flips in Gray order
	function automatic logic [2:0] low_bit(input logic [7:0] x);
		logic [2:0] r;
		r = '0;
		for (int b = 7; b >= 0; b--) if (x[b]) r = 3'(b);
		return r;
	endfunction

	state_t state_q, state_d;

	// configuration registers
	logic [3:0] row_lim_q;
	logic [7:0] state_lim_q;

	// window bookkeeping
	logic [7:0]      cnt_q;
	logic            err_q;
	logic [COLS-1:0] used_q;

	// memories: window rows and pivot rows
	logic [COLS-1:0] row_mem [ROWS];
	logic [COLS-1:0] piv_mem [COLS];
	logic [COLS-1:0] row_rd_q;
	logic [COLS-1:0] piv_rd_q;

	// sweep datapath
	logic [7:0]      idx_q;
	logic [7:0]      states_q;
	logic [COLS-1:0] gv_q;
	logic [COLS-1:0] v_q;
	logic [6:0]      w_q;
	logic [6:0]      nw_q;
	logic            nw_vld_q;
	logic [9:0]      tot_q;

	// newest accepted vector, held back until we know whether it is the last
	logic            pend_vld_q;
	logic [7:0]      pend_mask_q;
	logic [COLS-1:0] pend_row_q;
	logic [6:0]      pend_w_q;
	logic [9:0]      pend_tot_q;

	// output register
	logic      out_vld_q;
	out_item_t out_q;
	out_item_t out_d;

	logic        src_acc;
	logic [7:0]  cnt_nxt;
	logic [16:0] states_full;
	logic        cap_err;
	logic [6:0]  wt;
	logic [2:0]  flip_row;
	logic [7:0]  gray;
	logic [CIW-1:0] piv_idx;
	logic        out_free;
	logic        take;
	logic        nw_eff_vld;
	logic [6:0]  nw_eff;
	logic        adv;
	logic        pass_end;
	logic        hit;
	logic        accept_hit;
	logic        push_pend;
	logic        load_out;
	logic [9:0]  tot_nxt;

	assign cfg.ready = 1'b1;
	assign src.ready = (state_q == ST_LOAD);
	assign src_acc   = src.valid & src.ready;
	assign res.valid = out_vld_q;
	assign res.data  = out_q;
	assign out_free  = ~out_vld_q | res.ready;

	// row count saturates, the limits are judged on the count including this row
	assign cnt_nxt     = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
	assign states_full = (17'd1 << cnt_nxt[4:0]) - 17'd1;
	assign cap_err     = (cnt_nxt > 8'(ROWS)) || (cnt_nxt > {4'b0, row_lim_q}) ||
		(states_full > {9'b0, state_lim_q});

	assign wt       = pop_cnt(gv_q);
	assign flip_row = low_bit(idx_q);
	assign gray     = idx_q ^ (idx_q >> 1);
	assign pass_end = (idx_q == states_q);
	assign tot_nxt  = tot_q + {3'b0, w_q};

	// pivot of the vector under reduction
	always_comb begin
		piv_idx = '0;
		for (int b = 0; b < COLS; b++) if (v_q[b]) piv_idx = CIW'(b);
	end

	// track the smallest weight above the current class
	assign take       = (state_q == ST_CHK) && (wt > w_q) && (!nw_vld_q || wt < nw_q);
	assign nw_eff_vld = nw_vld_q | take;
	assign nw_eff     = take ? wt : nw_q;

	assign hit        = (state_q == ST_RED) && (v_q != '0) && !used_q[piv_idx];
	assign accept_hit = hit && (!pend_vld_q || out_free);
	assign push_pend  = accept_hit && pend_vld_q;
	assign adv        = ((state_q == ST_CHK) && (wt != w_q)) ||
		((state_q == ST_RED) && (v_q == '0)) || accept_hit;
	assign load_out   = push_pend || ((state_q == ST_FIN) && out_free);

	always_comb begin
		out_d = '0;
		if (push_pend) begin
			out_d.basis_mask = pend_mask_q;
			out_d.basis_row  = 64'(pend_row_q);
			out_d.weight     = pend_w_q;
			out_d.weight_sum = pend_tot_q;
		end else if (err_q) begin
			out_d.error = 1'b1;
			out_d.last  = 1'b1;
		end else if (pend_vld_q) begin
			out_d.basis_mask = pend_mask_q;
			out_d.basis_row  = 64'(pend_row_q);
			out_d.weight     = pend_w_q;
			out_d.weight_sum = pend_tot_q;
			out_d.last       = 1'b1;
		end else begin
			out_d.empty_res = 1'b1;
			out_d.last      = 1'b1;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (src_acc && src.data.last_row) state_d = cap_err ? ST_FIN : ST_RD;
			end
			ST_RD:  state_d = ST_GV;
			ST_GV:  state_d = ST_CHK;
			ST_CHK: if (wt == w_q) state_d = ST_RED;
			ST_RED: if (v_q != '0 && used_q[piv_idx]) state_d = ST_XOR;
			ST_XOR: state_d = ST_RED;
			ST_FIN: if (out_free) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
		// end of one offer: next combination, next weight class, or done
		if (adv) state_d = (!pass_end || nw_eff_vld) ? ST_RD : ST_FIN;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_lim_q   <= ROW_LIM_RST;
			state_lim_q <= STATE_LIM_RST;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			used_q      <= '0;
			nw_vld_q    <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_ROW_LIM:   row_lim_q <= cfg.data[3:0];
					REG_STATE_LIM: state_lim_q <= cfg.data;
					default: ;
				endcase
			end
			if (src_acc) begin
				cnt_q <= cnt_nxt;
				if (src.data.last_row) begin
					err_q      <= cap_err;
					used_q     <= '0;
					pend_vld_q <= 1'b0;
				end
			end
			if ((src_acc && src.data.last_row) || (adv && pass_end)) begin
				nw_vld_q <= 1'b0;
			end else if (take) begin
				nw_vld_q <= 1'b1;
			end
			if (accept_hit) begin
				used_q[piv_idx] <= 1'b1;
				pend_vld_q      <= 1'b1;
			end
			if (state_q == ST_FIN && out_free) cnt_q <= '0;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath and memories
	always_ff @(posedge clk) begin
		if (src_acc && cnt_q < 8'(ROWS)) row_mem[cnt_q[RIW-1:0]] <= src.data.row_bits[COLS-1:0];
		if (src_acc && src.data.last_row) begin
			w_q      <= '0;
			idx_q    <= 8'd1;
			gv_q     <= '0;
			tot_q    <= '0;
			states_q <= states_full[7:0];
		end
		if (state_q == ST_RD) row_rd_q <= row_mem[RIW'(flip_row)];
		if (state_q == ST_GV) gv_q <= gv_q ^ row_rd_q;
		if (state_q == ST_CHK && wt == w_q) v_q <= gv_q;
		if (take) nw_q <= wt;
		if (state_q == ST_RED && used_q[piv_idx]) piv_rd_q <= piv_mem[piv_idx];
		if (state_q == ST_XOR) v_q <= v_q ^ piv_rd_q;
		if (accept_hit) begin
			// the pivot keeps the reduced vector, the result the combination itself
			piv_mem[piv_idx] <= v_q;
			pend_mask_q      <= gray;
			pend_row_q       <= gv_q;
			pend_w_q         <= w_q;
			pend_tot_q       <= tot_nxt;
			tot_q            <= tot_nxt;
		end
		if (adv) begin
			if (!pass_end) begin
				idx_q <= idx_q + 8'd1;
			end else begin
				// restart the Gray walk for the next weight class
				idx_q <= 8'd1;
				gv_q  <= '0;
				w_q   <= nw_eff;
			end
		end
		if (load_out) out_q <= out_d;
	end

endmodule
`default_nettype wire

// File: rtl/core/mwgb_check.sv
`timescale 1ns / 1ps
`default_nettype none
module mwgb_check (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_ready,
	input logic                src_last,
	input logic                res_valid,
	input logic                res_ready,
	input mwgb_pkg::out_item_t res_data
);
	import mwgb_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.error |->
			res_data.last && !res_data.empty_res && res_data.weight == 7'd0)
		else $error("malformed error result");

	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.empty_res |->
			res_data.last && res_data.weight_sum == 10'd0 && res_data.basis_mask == 8'd0)
		else $error("malformed empty result");

	a_basis_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.error && !res_data.empty_res |->
			res_data.weight != 7'd0 && {3'b0, res_data.weight} <= res_data.weight_sum)
		else $error("basis weight inconsistent");

	a_sweep_stall: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && src_last |=> !src_ready)
		else $error("input taken right after window close");

endmodule

bind min_weight_gf2_basis mwgb_check u_mwgb_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src.valid),
	.src_ready (src.ready),
	.src_last  (src.data.last_row),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire
